@@ src/whpd_pkg.sv @@
// Package for the weighted pair distance histogram.
// Holds the shared types, codes, widths and the saturating add; all modules but whpd_ram and the checker use it.
package whpd_pkg;

    localparam int unsigned MAX_ATOMS_DEF  = 1024;
    localparam int unsigned MAX_WATERS_DEF = 1024;
    localparam int unsigned BINS_DEF       = 64;

    localparam int unsigned CFG_W     = 12;
    localparam int unsigned PT_W      = 64;
    localparam int unsigned SUM_W     = 48;
    localparam int unsigned VAL_W     = 33;
    localparam int unsigned BIN_W     = 6;
    localparam int unsigned RAD_W     = 34;
    localparam int unsigned ROOT_W    = 17;
    localparam int unsigned REM_W     = 20;
    localparam int unsigned SQ_STEPS  = 17;
    localparam int unsigned MIN_KEPT  = 10;
    localparam int unsigned OUT_TDATA_W = 200;
    localparam logic [CFG_W-1:0] BIN_WIDTH_RST = 12'd16;

    typedef enum logic [1:0] {
        OP_LOAD_ATOM  = 2'd0,
        OP_LOAD_WATER = 2'd1,
        OP_COMPUTE    = 2'd2,
        OP_NONE       = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CLS_AA = 2'd0,
        CLS_WW = 2'd1,
        CLS_WA = 2'd2
    } t_cls;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AA_OUT,
        ST_AA_IN,
        ST_WW_OUT,
        ST_WW_IN,
        ST_WA_OUT,
        ST_WA_IN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             vld;
        t_cls             cls;
        logic [VAL_W-1:0] val;
    } t_tok;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_sqs;

    typedef struct packed {
        logic             vld;
        t_cls             cls;
        logic [BIN_W-1:0] bin;
        logic [VAL_W-1:0] val;
    } t_btok;

    typedef struct packed {
        logic [SUM_W-1:0] aa;
        logic [SUM_W-1:0] ww;
        logic [SUM_W-1:0] wa;
    } t_sums;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

@@ src/weighted_pair_distance_histogram.sv @@
// Top level of the weighted pair distance histogram.
// Depends on whpd_pkg, whpd_ram, whpd_sqrt_cell, whpd_div_cell and whpd_bin_cell.
//
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tdata: x_coord, y_coord, z_coord, point_weight; tuser: opcode
// m_axis    out  tdata: bin_index, atom_atom_sum, water_water_sum, water_atom_sum,
//                total_sum; tlast: last_bin
// cfg       in   i_cfg_we, i_cfg_wdata: bin_width
//
// Load transfers are taken while idle. A compute walks the atom-atom, water-water and
// water-atom pair sets in turn, then drains through the square root, divider and bin
// cell chain, then emits one bin per output transfer.
// Reset is synchronous and needs no clearing pass; the point stores are undefined
// until written. An output stall holds the emitted bin and blocks new input.
module weighted_pair_distance_histogram #(
    parameter int unsigned MAX_ATOMS  = whpd_pkg::MAX_ATOMS_DEF,
    parameter int unsigned MAX_WATERS = whpd_pkg::MAX_WATERS_DEF,
    parameter int unsigned BINS       = whpd_pkg::BINS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [whpd_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // x_coord, y_coord, z_coord, point_weight
    input  logic [whpd_pkg::PT_W-1:0]           s_axis_tdata,
    // opcode
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bin_index, atom_atom_sum, water_water_sum, water_atom_sum, total_sum, zero pad
    output logic [whpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);
    import whpd_pkg::*;

    localparam int unsigned AAW = $clog2(MAX_ATOMS);
    localparam int unsigned WAW = (MAX_WATERS > 1) ? $clog2(MAX_WATERS) : 1;
    localparam int unsigned ACW = $clog2(MAX_ATOMS + 1);
    localparam int unsigned WCW = $clog2(MAX_WATERS + 1);
    localparam int unsigned CW  = (ACW > WCW) ? ACW : WCW;
    localparam int unsigned BW  = $clog2(BINS);
    localparam int unsigned QW  = BW + 1;
    localparam int unsigned DRAIN_LAST = 1 + 3 + SQ_STEPS + QW + 1 + BINS + 2;
    localparam int unsigned DCW = $clog2(DRAIN_LAST + 1);

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_bw;
    logic [ACW-1:0]   r_acnt, n_acnt;
    logic [WCW-1:0]   r_wcnt, n_wcnt;
    logic [CW-1:0]    r_i, n_i, r_j, n_j;
    logic [DCW-1:0]   r_drain, n_drain;
    logic [BW-1:0]    r_emit, n_emit;

    logic in_xfer, out_xfer;
    t_opcode op;
    logic atom_we, water_we, iss_outer, iss_inner, clear, shift;
    t_cls iss_cls;
    logic [AAW-1:0] atom_addr;
    logic [WAW-1:0] water_addr;
    logic [PT_W-1:0] atom_rd, water_rd;

    assign op       = t_opcode'(s_axis_tuser);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_xfer && op == OP_COMPUTE) n_state = ST_AA_OUT;
            ST_AA_OUT: n_state = (r_i != CW'(r_acnt)) ? ST_AA_IN : ST_WW_OUT;
            ST_AA_IN:  if (r_j == CW'(r_acnt)) n_state = ST_AA_OUT;
            ST_WW_OUT: n_state = (r_i != CW'(r_wcnt)) ? ST_WW_IN : ST_WA_OUT;
            ST_WW_IN:  if (r_j == CW'(r_wcnt)) n_state = ST_WW_OUT;
            ST_WA_OUT: n_state = (r_i != CW'(r_wcnt)) ? ST_WA_IN : ST_DRAIN;
            ST_WA_IN:  if (r_j == CW'(r_acnt)) n_state = ST_WA_OUT;
            ST_DRAIN:  if (r_drain == DCW'(DRAIN_LAST)) n_state = ST_EMIT;
            ST_EMIT:   if (out_xfer && m_axis_tlast) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_acnt = r_acnt;
        n_wcnt = r_wcnt;
        n_drain = r_drain;
        n_emit = r_emit;
        atom_addr = r_i[AAW-1:0];
        water_addr = r_i[WAW-1:0];
        atom_we = 1'b0;
        water_we = 1'b0;
        iss_outer = 1'b0;
        iss_inner = 1'b0;
        iss_cls = CLS_AA;
        clear = 1'b0;
        shift = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_emit = '0;
                if (in_xfer) begin
                    case (op)
                        OP_LOAD_ATOM: begin
                            atom_addr = r_acnt[AAW-1:0];
                            if (r_acnt != ACW'(MAX_ATOMS)) begin
                                atom_we = 1'b1;
                                n_acnt = r_acnt + 1'b1;
                            end
                        end
                        OP_LOAD_WATER: begin
                            water_addr = r_wcnt[WAW-1:0];
                            if (r_wcnt != WCW'(MAX_WATERS)) begin
                                water_we = 1'b1;
                                n_wcnt = r_wcnt + 1'b1;
                            end
                        end
                        OP_COMPUTE: begin
                            clear = 1'b1;
                            n_i = '0;
                        end
                        default: clear = 1'b0;
                    endcase
                end
            end
            ST_AA_OUT: begin
                if (r_i != CW'(r_acnt)) begin
                    iss_outer = 1'b1;
                    n_j = r_i + 1'b1;
                end else begin
                    n_i = '0;
                end
            end
            ST_AA_IN: begin
                atom_addr = r_j[AAW-1:0];
                if (r_j != CW'(r_acnt)) begin
                    iss_inner = 1'b1;
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_WW_OUT: begin
                iss_cls = CLS_WW;
                if (r_i != CW'(r_wcnt)) begin
                    iss_outer = 1'b1;
                    n_j = r_i + 1'b1;
                end else begin
                    n_i = '0;
                end
            end
            ST_WW_IN: begin
                iss_cls = CLS_WW;
                water_addr = r_j[WAW-1:0];
                if (r_j != CW'(r_wcnt)) begin
                    iss_inner = 1'b1;
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_WA_OUT: begin
                iss_cls = CLS_WA;
                if (r_i != CW'(r_wcnt)) begin
                    iss_outer = 1'b1;
                    n_j = '0;
                end else begin
                    n_drain = '0;
                end
            end
            ST_WA_IN: begin
                iss_cls = CLS_WA;
                atom_addr = r_j[AAW-1:0];
                if (r_j != CW'(r_acnt)) begin
                    iss_inner = 1'b1;
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_DRAIN: n_drain = r_drain + 1'b1;
            ST_EMIT: begin
                if (out_xfer) begin
                    shift = 1'b1;
                    n_emit = r_emit + 1'b1;
                end
            end
            default: n_emit = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bw    <= BIN_WIDTH_RST;
            r_acnt  <= '0;
            r_wcnt  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_drain <= '0;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_bw <= i_cfg_wdata;
            end
            r_acnt  <= n_acnt;
            r_wcnt  <= n_wcnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_drain <= n_drain;
            r_emit  <= n_emit;
        end
    end

    whpd_ram #(.WIDTH(PT_W), .DEPTH(MAX_ATOMS)) u_atom_ram (
        .i_clk(i_clk), .i_we(atom_we), .i_waddr(atom_addr), .i_wdata(s_axis_tdata),
        .i_raddr(atom_addr), .o_rdata(atom_rd)
    );

    whpd_ram #(.WIDTH(PT_W), .DEPTH(MAX_WATERS)) u_water_ram (
        .i_clk(i_clk), .i_we(water_we), .i_waddr(water_addr), .i_wdata(s_axis_tdata),
        .i_raddr(water_addr), .o_rdata(water_rd)
    );

    // Read return and pair formation.
    logic r_out_v, r_in_v;
    t_cls r_rcls;
    logic [PT_W-1:0] r_pa;
    logic [PT_W-1:0] outer_src, inner_src, pa, pb;
    logic tok_v, tok_self;

    always_comb begin
        outer_src = (r_rcls == CLS_AA) ? atom_rd : water_rd;
        inner_src = (r_rcls == CLS_WW) ? water_rd : atom_rd;
        pa = r_out_v ? outer_src : r_pa;
        pb = r_out_v ? outer_src : inner_src;
        tok_self = r_out_v;
        tok_v = r_in_v || (r_out_v && r_rcls != CLS_WA);
    end

    logic r1_v, r1_self;
    t_cls r1_cls;
    logic signed [16:0] r1_dx, r1_dy, r1_dz;
    logic [15:0] r1_wa, r1_wb;
    logic signed [33:0] sqx, sqy, sqz;
    logic r2_v, r2_self;
    t_cls r2_cls;
    logic [31:0] r2_sqx, r2_sqy, r2_sqz, r2_prod;
    t_tok r3_tok;
    logic [RAD_W-1:0] r3_d2;

    assign sqx = r1_dx * r1_dx;
    assign sqy = r1_dy * r1_dy;
    assign sqz = r1_dz * r1_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_in_v  <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_tok.vld <= 1'b0;
        end else begin
            r_out_v <= iss_outer;
            r_in_v  <= iss_inner;
            r1_v    <= tok_v;
            r2_v    <= r1_v;
            r3_tok.vld <= r2_v;
        end
        r_rcls <= iss_cls;
        if (r_out_v) begin
            r_pa <= outer_src;
        end
        r1_self <= tok_self;
        r1_cls  <= r_rcls;
        r1_dx   <= $signed({pa[15], pa[15:0]}) - $signed({pb[15], pb[15:0]});
        r1_dy   <= $signed({pa[31], pa[31:16]}) - $signed({pb[31], pb[31:16]});
        r1_dz   <= $signed({pa[47], pa[47:32]}) - $signed({pb[47], pb[47:32]});
        r1_wa   <= pa[63:48];
        r1_wb   <= pb[63:48];
        r2_self <= r1_self;
        r2_cls  <= r1_cls;
        r2_sqx  <= sqx[31:0];
        r2_sqy  <= sqy[31:0];
        r2_sqz  <= sqz[31:0];
        r2_prod <= r1_wa * r1_wb;
        r3_tok.cls <= r2_cls;
        r3_tok.val <= r2_self ? {1'b0, r2_prod} : {r2_prod, 1'b0};
        r3_d2   <= RAD_W'(r2_sqx) + RAD_W'(r2_sqy) + RAD_W'(r2_sqz);
    end

    // Square root chain.
    t_tok sq_tok [SQ_STEPS+1];
    t_sqs sq_st  [SQ_STEPS+1];

    assign sq_tok[0] = r3_tok;
    assign sq_st[0]  = '{rem: '0, root: '0, rad: r3_d2};

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sq
        whpd_sqrt_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_tok(sq_tok[s]), .i_sqs(sq_st[s]),
            .o_tok(sq_tok[s+1]), .o_sqs(sq_st[s+1])
        );
    end

    // Division chain, most significant quotient bit first.
    logic [CFG_W-1:0] eff_w;
    t_tok dv_tok [QW+1];
    logic [ROOT_W-1:0] dv_rem [QW+1];
    logic [QW-1:0] dv_q [QW+1];

    assign eff_w = (r_bw == '0) ? CFG_W'(1) : r_bw;
    assign dv_tok[0] = sq_tok[SQ_STEPS];
    assign dv_rem[0] = sq_st[SQ_STEPS].root;
    assign dv_q[0]   = '0;

    for (genvar d = 0; d < QW; d++) begin : g_dv
        whpd_div_cell #(.QW(QW), .K(QW - 1 - d)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_width(eff_w),
            .i_tok(dv_tok[d]), .i_rem(dv_rem[d]), .i_q(dv_q[d]),
            .o_tok(dv_tok[d+1]), .o_rem(dv_rem[d+1]), .o_q(dv_q[d+1])
        );
    end

    // Clamp, track the highest bin that gets a nonzero contribution.
    t_btok r_btok;
    logic [BIN_W-1:0] bin_c;
    logic r_hi_v;
    logic [BIN_W-1:0] r_hi;
    logic [BW-1:0] last_idx;

    assign bin_c = (dv_q[QW] >= QW'(BINS)) ? BIN_W'(BINS - 1) : BIN_W'(dv_q[QW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btok.vld <= 1'b0;
            r_hi_v <= 1'b0;
        end else begin
            r_btok.vld <= dv_tok[QW].vld;
            if (clear) begin
                r_hi_v <= 1'b0;
            end else if (r_btok.vld && r_btok.val != '0 && (!r_hi_v || r_btok.bin > r_hi)) begin
                r_hi_v <= 1'b1;
            end
        end
        r_btok.cls <= dv_tok[QW].cls;
        r_btok.bin <= bin_c;
        r_btok.val <= dv_tok[QW].val;
        if (r_btok.vld && r_btok.val != '0 && (!r_hi_v || r_btok.bin > r_hi)) begin
            r_hi <= r_btok.bin;
        end
    end

    assign last_idx = (r_hi_v && r_hi > BIN_W'(MIN_KEPT - 1)) ? r_hi[BW-1:0]
                                                               : BW'(MIN_KEPT - 1);

    // Bin cell chain: tokens travel up, sums shift down toward bin 0 on emission.
    t_btok bt [BINS+1];
    t_sums sm [BINS+1];

    assign bt[0]    = r_btok;
    assign sm[BINS] = '0;

    for (genvar b = 0; b < BINS; b++) begin : g_bin
        whpd_bin_cell #(.IDX(b)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(clear), .i_shift(shift),
            .i_tok(bt[b]), .i_up(sm[b+1]), .o_tok(bt[b+1]), .o_sums(sm[b])
        );
    end

    logic [SUM_W+1:0] tot;
    logic [SUM_W-1:0] tot_sat;

    always_comb begin
        tot = (SUM_W+2)'(sm[0].aa) + (SUM_W+2)'(sm[0].ww) + {1'b0, sm[0].wa, 1'b0};
        tot_sat = (tot[SUM_W+1:SUM_W] != 2'b00) ? {SUM_W{1'b1}} : tot[SUM_W-1:0];
    end

    assign m_axis_tdata = {2'b00, tot_sat, sm[0].wa, sm[0].ww, sm[0].aa, BIN_W'(r_emit)};
    assign m_axis_tlast = (r_emit == last_idx);
endmodule

@@ src/whpd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module whpd_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/whpd_sqrt_cell.sv @@
// One digit step of the integer square root chain.
// Depends on whpd_pkg.
module whpd_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  whpd_pkg::t_tok i_tok,
    input  whpd_pkg::t_sqs i_sqs,
    output whpd_pkg::t_tok o_tok,
    output whpd_pkg::t_sqs o_sqs
);
    import whpd_pkg::*;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    t_sqs             n_sqs;
    t_tok             r_tok;
    t_sqs             r_sqs;

    always_comb begin
        rem_sh = {i_sqs.rem[REM_W-3:0], i_sqs.rad[RAD_W-1 -: 2]};
        trial  = REM_W'({i_sqs.root, 2'b01});
        ge     = (rem_sh >= trial);
        n_sqs.rem  = ge ? (rem_sh - trial) : rem_sh;
        n_sqs.root = {i_sqs.root[ROOT_W-2:0], ge};
        n_sqs.rad  = {i_sqs.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.cls <= i_tok.cls;
        r_tok.val <= i_tok.val;
        r_sqs     <= n_sqs;
    end

    assign o_tok = r_tok;
    assign o_sqs = r_sqs;
endmodule

@@ src/whpd_div_cell.sv @@
// One quotient bit of the distance-by-bin-width division chain.
// Depends on whpd_pkg.
module whpd_div_cell #(
    parameter int unsigned QW = 7,
    parameter int unsigned K  = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [whpd_pkg::CFG_W-1:0]      i_width,
    input  whpd_pkg::t_tok                  i_tok,
    input  logic [whpd_pkg::ROOT_W-1:0]     i_rem,
    input  logic [QW-1:0]                   i_q,
    output whpd_pkg::t_tok                  o_tok,
    output logic [whpd_pkg::ROOT_W-1:0]     o_rem,
    output logic [QW-1:0]                   o_q
);
    import whpd_pkg::*;

    localparam int unsigned DVW = CFG_W + QW;

    logic [DVW-1:0]    rem_x;
    logic [DVW-1:0]    dv;
    logic              ge;
    logic [QW-1:0]     n_q;
    t_tok              r_tok;
    logic [ROOT_W-1:0] r_rem;
    logic [QW-1:0]     r_q;

    always_comb begin
        rem_x = DVW'(i_rem);
        dv    = DVW'(i_width) << K;
        ge    = (rem_x >= dv);
        n_q   = i_q;
        n_q[K] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.cls <= i_tok.cls;
        r_tok.val <= i_tok.val;
        r_rem     <= ge ? ROOT_W'(rem_x - dv) : i_rem;
        r_q       <= n_q;
    end

    assign o_tok = r_tok;
    assign o_rem = r_rem;
    assign o_q   = r_q;
endmodule

@@ src/whpd_bin_cell.sv @@
// One histogram bin: accumulates passing pair contributions and shifts out on emission.
// Depends on whpd_pkg.
module whpd_bin_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_shift,
    input  whpd_pkg::t_btok i_tok,
    input  whpd_pkg::t_sums i_up,
    output whpd_pkg::t_btok o_tok,
    output whpd_pkg::t_sums o_sums
);
    import whpd_pkg::*;

    t_btok r_tok;
    t_sums r_sums;
    t_sums n_sums;
    logic  hit;

    always_comb begin
        hit    = i_tok.vld && (i_tok.bin == BIN_W'(IDX));
        n_sums = r_sums;
        if (i_clear) begin
            n_sums = '0;
        end else if (i_shift) begin
            n_sums = i_up;
        end else if (hit) begin
            case (i_tok.cls)
                CLS_AA:  n_sums.aa = sat_add(r_sums.aa, i_tok.val);
                CLS_WW:  n_sums.ww = sat_add(r_sums.ww, i_tok.val);
                CLS_WA:  n_sums.wa = sat_add(r_sums.wa, i_tok.val);
                default: n_sums = r_sums;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.cls <= i_tok.cls;
        r_tok.bin <= i_tok.bin;
        r_tok.val <= i_tok.val;
        r_sums    <= n_sums;
    end

    assign o_tok  = r_tok;
    assign o_sums = r_sums;
endmodule

@@ src/whpd_checker.sv @@
// Port-level checker for the weighted pair distance histogram, with its bind.
// Depends on the top level's ports only.
module whpd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [199:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    a_no_input_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during emission");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

    a_bins_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && (m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1))
        else $error("bin index out of order");

    a_first_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> m_axis_tdata[5:0] == 6'd0)
        else $error("histogram does not start at bin zero");

    a_total_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[197:150] >= m_axis_tdata[53:6])
        else $error("total below atom-atom sum");
endmodule

bind weighted_pair_distance_histogram whpd_checker u_whpd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
